@@ rtl/core/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");

// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error("forbidden condition");

`endif

@@ rtl/core/mfr_pkg.sv @@
// types, constants and functions of the modbus frame receiver
package mfr_pkg;

	localparam int unsigned STORE_DEPTH = 256;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned LEN_W       = 9;
	localparam int unsigned HDR_N       = 13;
	localparam int unsigned HDR_IW      = $clog2(HDR_N);

	typedef enum logic [1:0] {
		LM_RTU   = 2'd0,
		LM_ASCII = 2'd1,
		LM_TCP   = 2'd2,
		LM_PDU   = 2'd3
	} link_mode_t;

	typedef enum logic [2:0] {
		CFG_LINK_MODE   = 3'd0,
		CFG_PARSE_REQ   = 3'd1,
		CFG_BUF_LIMIT   = 3'd2,
		CFG_CHECK_TXN   = 3'd3,
		CFG_EXPECT_TXN  = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_SHORT     = 3'd1,
		ERR_CHECKSUM  = 3'd2,
		ERR_MBAP      = 3'd3,
		ERR_FUNCTION  = 3'd4,
		ERR_TRUNCATED = 3'd5,
		ERR_TXN       = 3'd6
	} err_t;

	typedef enum logic {
		PH_LISTEN = 1'b0,
		PH_RECV   = 1'b1
	} phase_t;

	typedef enum logic [2:0] {
		FC_NONE,
		FC_BASE,
		FC_VAR,
		FC_FULL,
		FC_CODE,
		FC_CALL
	} fc_class_t;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
		logic       end_of_frame;
		logic [7:0] read_index;
	} mfr_in_t;

	typedef struct packed {
		logic             result_kind;
		logic             frame_ok;
		logic [2:0]       error_cause;
		logic [7:0]       unit_address;
		logic [7:0]       function_code;
		logic [15:0]      register_address;
		logic [15:0]      register_count;
		logic [7:0]       length_or_code;
		logic [15:0]      transaction_id;
		logic [LEN_W-1:0] data_start;
		logic [LEN_W-1:0] frame_length;
		logic [7:0]       read_data;
	} mfr_out_t;

	typedef logic [HDR_N-1:0][7:0] hdr_t;

	// crc-16 (reflected 0xa001), one byte
	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic fc_class_t classify(input logic [7:0] f, input logic req);
		fc_class_t t;
		if (f[7]) begin
			t = FC_CODE;
		end else begin
			unique case (f)
				8'h01, 8'h02, 8'h03, 8'h04: t = req ? FC_BASE : FC_VAR;
				8'h05, 8'h06:               t = FC_BASE;
				8'h07:                      t = req ? FC_CALL : FC_CODE;
				8'h0B:                      t = req ? FC_CALL : FC_BASE;
				8'h0C, 8'h11:               t = req ? FC_CALL : FC_VAR;
				8'h0F, 8'h10:               t = req ? FC_FULL : FC_BASE;
				8'h14, 8'h15:               t = FC_VAR;
				default:                    t = FC_NONE;
			endcase
		end
		return t;
	endfunction

endpackage

@@ rtl/core/modbus_frame_receiver.sv @@
// modbus frame receiver top level: byte intake, frame state and result register
//
//   channel | signals                         | beat taken when
//   in      | in_valid in_ready in_data       | in_valid && in_ready
//   out     | out_valid out_ready out_data    | out_valid && out_ready
//   cfg     | cfg_we cfg_index cfg_data       | cfg_we
//
// one beat per cycle while intake is not stalled: a beat goes to the input stage, and as it
// advances from there it updates the running crc/lrc and header bytes and loads the result register.
// store reads are answered from the memory read port, registered at intake.
// reset puts the block in listening with an empty frame; no clearing pass.
// a held result stalls intake only when the beat in the input stage has a result.
module modbus_frame_receiver (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mfr_pkg::mfr_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output mfr_pkg::mfr_out_t out_data,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import mfr_pkg::*;

	// configuration
	logic [1:0]       link_mode_q;
	logic             parse_req_q;
	logic [LEN_W-1:0] limit_q;
	logic             check_txn_q;
	logic [15:0]      expect_txn_q;

	// input stage
	logic             valid_s1;
	mfr_in_t          data_s1;
	logic             in_range_s1;
	logic [7:0]       rdata_s1;

	// frame state
	phase_t           phase_q, phase_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic             half_q, half_n;
	logic [3:0]       hi_q, hi_n;
	logic [15:0]      crc_q, crc_n;
	logic [7:0]       lrc_q, lrc_n;
	hdr_t             hdr_q, hdr_n;

	// post-put values seen by the frame checks
	logic [LEN_W-1:0] acc_len;
	logic [15:0]      acc_crc;
	logic [7:0]       acc_lrc;

	logic             put, clr, finish, hex_ok;
	logic [7:0]       put_b;
	logic [3:0]       nib;
	logic             mem_we;
	logic [7:0]       mem_wd;
	logic [LEN_W-1:0] lim;
	logic             produce, advance, accept;

	logic             out_valid_q;
	mfr_out_t         out_q, report, result;

	assign lim = (limit_q > LEN_W'(STORE_DEPTH)) ? LEN_W'(STORE_DEPTH) : limit_q;

	always_comb begin
		hex_ok = 1'b1;
		nib    = 4'h0;
		if (data_s1.rx_byte >= 8'h30 && data_s1.rx_byte <= 8'h39) begin
			nib = 4'(data_s1.rx_byte - 8'h30);
		end else if (data_s1.rx_byte >= 8'h41 && data_s1.rx_byte <= 8'h46) begin
			nib = 4'(data_s1.rx_byte - 8'h37);
		end else if (data_s1.rx_byte >= 8'h61 && data_s1.rx_byte <= 8'h66) begin
			nib = 4'(data_s1.rx_byte - 8'h57);
		end else begin
			hex_ok = 1'b0;
		end
	end

	// next frame state
	always_comb begin
		phase_n = phase_q;
		half_n  = half_q;
		hi_n    = hi_q;
		hdr_n   = hdr_q;
		put     = 1'b0;
		put_b   = data_s1.rx_byte;
		clr     = 1'b0;
		finish  = 1'b0;
		mem_we  = 1'b0;
		mem_wd  = data_s1.rx_byte;
		acc_len = len_q;
		acc_crc = crc_q;
		acc_lrc = lrc_q;

		if (valid_s1 && !data_s1.kind) begin
			if (link_mode_t'(link_mode_q) != LM_ASCII) begin
				put    = (len_q < lim);
				finish = data_s1.end_of_frame;
			end else if (data_s1.rx_byte == CH_COLON) begin
				clr     = 1'b1;
				phase_n = PH_RECV;
			end else if (phase_q == PH_RECV) begin
				if (data_s1.rx_byte == CH_CR || data_s1.rx_byte == CH_LF) begin
					finish = (data_s1.rx_byte == CH_LF) || data_s1.end_of_frame;
				end else if (len_q >= lim || !hex_ok) begin
					clr     = 1'b1;
					phase_n = PH_LISTEN;
				end else if (half_q) begin
					put    = 1'b1;
					put_b  = {hi_q, nib};
					half_n = 1'b0;
				end else begin
					// first nibble lands in the store as the high half
					mem_we = 1'b1;
					mem_wd = {nib, 4'h0};
					hi_n   = nib;
					half_n = 1'b1;
				end
			end
		end

		if (put) begin
			mem_we  = 1'b1;
			mem_wd  = put_b;
			acc_len = len_q + LEN_W'(1);
			acc_crc = crc_step(crc_q, put_b);
			acc_lrc = lrc_q + put_b;
			if (len_q < LEN_W'(HDR_N)) begin
				hdr_n[HDR_IW'(len_q)] = put_b;
			end
		end

		if (valid_s1 && !data_s1.kind) begin
			if (link_mode_t'(link_mode_q) != LM_ASCII) begin
				if (acc_len != '0) begin
					phase_n = PH_RECV;
				end
			end else if (phase_q == PH_RECV && data_s1.rx_byte != CH_COLON
					&& data_s1.rx_byte != CH_CR && data_s1.rx_byte != CH_LF
					&& !clr && data_s1.end_of_frame && acc_len != '0) begin
				finish = 1'b1;
			end
		end

		len_n = acc_len;
		crc_n = acc_crc;
		lrc_n = acc_lrc;
		if (finish || clr) begin
			len_n  = '0;
			half_n = 1'b0;
			crc_n  = CRC_INIT;
			lrc_n  = 8'h00;
		end
		if (finish) begin
			phase_n = PH_LISTEN;
		end
	end

	mfr_report u_report (
		.link_mode            (link_mode_q),
		.parse_as_request     (parse_req_q),
		.check_transaction    (check_txn_q),
		.expected_transaction (expect_txn_q),
		.len                  (acc_len),
		.crc                  (acc_crc),
		.lrc                  (acc_lrc),
		.hdr                  (hdr_n),
		.report               (report)
	);

	// result of the beat in the input stage
	always_comb begin
		result = report;
		if (data_s1.kind) begin
			result             = '0;
			result.result_kind = 1'b1;
			result.read_data   = in_range_s1 ? rdata_s1 : 8'h00;
		end
	end

	assign produce  = valid_s1 && (data_s1.kind || finish);
	assign advance  = valid_s1 && (!produce || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	mfr_store u_store (
		.clk      (clk),
		.we       (advance && mem_we),
		.waddr    (ADDR_W'(len_q)),
		.wdata    (mem_wd),
		.re       (accept),
		.raddr    (ADDR_W'(in_data.read_index)),
		.rdata_s1 (rdata_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_mode_q  <= LM_RTU;
			parse_req_q  <= 1'b1;
			limit_q      <= LEN_W'(256);
			check_txn_q  <= 1'b0;
			expect_txn_q <= 16'h0000;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LINK_MODE:  link_mode_q  <= cfg_data[1:0];
				CFG_PARSE_REQ:  parse_req_q  <= cfg_data[0];
				CFG_BUF_LIMIT:  limit_q      <= cfg_data[LEN_W-1:0];
				CFG_CHECK_TXN:  check_txn_q  <= cfg_data[0];
				CFG_EXPECT_TXN: expect_txn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1     <= in_data;
			in_range_s1 <= (32'(in_data.read_index) < STORE_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LISTEN;
			len_q   <= '0;
			half_q  <= 1'b0;
			hi_q    <= 4'h0;
			crc_q   <= CRC_INIT;
			lrc_q   <= 8'h00;
		end else if (advance) begin
			phase_q <= phase_n;
			len_q   <= len_n;
			half_q  <= half_n;
			hi_q    <= hi_n;
			crc_q   <= crc_n;
			lrc_q   <= lrc_n;
		end
	end

	// header bytes are only read below the frame length, no reset needed
	always_ff @(posedge clk) begin
		if (advance) begin
			hdr_q <= hdr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/core/mfr_store.sv @@
// frame store memory with one write and one registered read port
module mfr_store (
	input  logic                      clk,
	input  logic                      we,
	input  logic [mfr_pkg::ADDR_W-1:0] waddr,
	input  logic [7:0]                wdata,
	input  logic                      re,
	input  logic [mfr_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                rdata_s1
);
	import mfr_pkg::*;

	logic [7:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// a write landing at the same edge wins over the old entry
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

endmodule

@@ rtl/core/mfr_report.sv @@
// frame end checks and header field extraction
module mfr_report (
	input  logic [1:0]               link_mode,
	input  logic                     parse_as_request,
	input  logic                     check_transaction,
	input  logic [15:0]              expected_transaction,
	input  logic [mfr_pkg::LEN_W-1:0] len,
	input  logic [15:0]              crc,
	input  logic [7:0]               lrc,
	input  mfr_pkg::hdr_t            hdr,
	output mfr_pkg::mfr_out_t        report
);
	import mfr_pkg::*;

	logic [7:0]       w [6];
	logic [15:0]      decl;
	logic [16:0]      blen;
	logic [LEN_W-1:0] base;
	err_t             err;
	fc_class_t        t;
	logic             off5;

	// payload window starting at the function byte
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			unique case (link_mode_t'(link_mode))
				LM_TCP:  w[k] = hdr[7 + k];
				LM_PDU:  w[k] = hdr[k];
				default: w[k] = hdr[1 + k];
			endcase
		end
	end

	assign decl = {hdr[4], hdr[5]};

	always_comb begin
		report              = '0;
		report.frame_length = len;
		err                 = ERR_NONE;
		blen                = '0;
		base                = '0;
		t                   = FC_NONE;
		off5                = 1'b0;
		unique case (link_mode_t'(link_mode))
			LM_RTU: begin
				base = LEN_W'(1);
				if (len < LEN_W'(4)) begin
					err = ERR_SHORT;
				end else if (crc != 16'h0000) begin
					err = ERR_CHECKSUM;
				end else begin
					report.unit_address = hdr[0];
					blen = 17'(len) - 17'd3;
				end
			end
			LM_ASCII: begin
				base = LEN_W'(1);
				if (len < LEN_W'(3)) begin
					err = ERR_SHORT;
				end else if (lrc != 8'h00) begin
					err = ERR_CHECKSUM;
				end else begin
					report.unit_address = hdr[0];
					blen = 17'(len) - 17'd2;
				end
			end
			LM_TCP: begin
				base = LEN_W'(7);
				if (len < LEN_W'(8)) begin
					err = ERR_SHORT;
				end else if (decl < 16'd2 || 17'(len) < (17'd6 + 17'(decl))
						|| {hdr[2], hdr[3]} != 16'h0000) begin
					err = ERR_MBAP;
				end else begin
					report.transaction_id = {hdr[0], hdr[1]};
					report.unit_address   = hdr[6];
					blen = 17'(decl) - 17'd1;
				end
			end
			LM_PDU: begin
				if (len == '0) begin
					err = ERR_SHORT;
				end else begin
					blen = 17'(len);
				end
			end
			default: err = ERR_SHORT;
		endcase

		if (err == ERR_NONE) begin
			report.function_code = w[0];
			t = classify(w[0], parse_as_request);
			if (t == FC_NONE) begin
				err = ERR_FUNCTION;
			end
			if (err == ERR_NONE && (t == FC_BASE || t == FC_FULL)) begin
				if (blen < 17'd5) begin
					err = ERR_TRUNCATED;
				end else begin
					report.register_address = {w[1], w[2]};
					report.register_count   = {w[3], w[4]};
					off5 = 1'b1;
				end
			end
			if (err == ERR_NONE && (t == FC_VAR || t == FC_FULL)) begin
				if (blen < (off5 ? 17'd6 : 17'd2)) begin
					err = ERR_TRUNCATED;
				end else begin
					report.length_or_code = off5 ? w[5] : w[1];
					report.data_start     = base + (off5 ? LEN_W'(6) : LEN_W'(2));
				end
			end
			if (err == ERR_NONE && t == FC_CODE) begin
				if (blen < 17'd2) begin
					err = ERR_TRUNCATED;
				end else begin
					report.length_or_code = w[1];
				end
			end
			if (err == ERR_NONE && link_mode_t'(link_mode) == LM_TCP && check_transaction
					&& report.transaction_id != expected_transaction) begin
				err = ERR_TXN;
			end
		end
		report.frame_ok    = (err == ERR_NONE);
		report.error_cause = err;
	end

endmodule

@@ rtl/core/mfr_checker.sv @@
// port level checks of the modbus frame receiver, bound to the top level
module mfr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input mfr_pkg::mfr_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input mfr_pkg::mfr_out_t out_data
);
	import mfr_pkg::*;
	`include "assert_macros.svh"

	// an offered input beat waits with its payload until taken
	`ASSERT_CLK(a_in_hold, clk, arst_n, (in_valid && !in_ready) |=> (in_valid && $stable(in_data)))

	// a held result beat keeps its payload
	`ASSERT_CLK(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))

	// report ok flag and cause agree
	`ASSERT_CLK(a_ok_cause, clk, arst_n, (out_valid && !out_data.result_kind) |-> (out_data.frame_ok == (out_data.error_cause == ERR_NONE)))

	// reports never carry read data
	`ASSERT_NEVER(a_rep_rdata, clk, arst_n, out_valid && !out_data.result_kind && out_data.read_data != 8'h00)

	// read beats carry nothing but the data byte
	`ASSERT_NEVER(a_read_clean, clk, arst_n, out_valid && out_data.result_kind && (out_data.frame_ok || out_data.frame_length != '0 || out_data.function_code != 8'h00))

endmodule

bind modbus_frame_receiver mfr_checker u_mfr_checker (.*);
